[design/spq_pkg.sv]
// Package with the types, constants and codes shared by the sorted priority queue.
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int VAL_W    = 32;
  localparam int OCC_W    = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_t;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] data;
    logic [1:0]              status;
    logic [OCC_W-1:0]        occupancy;
  } out_item_t;

  typedef struct packed {
    cell_op_t                op;
    logic signed [VAL_W-1:0] ins_value;
    logic                    left_less;
    logic                    left_valid;
    logic signed [VAL_W-1:0] left_value;
    logic                    right_valid;
    logic signed [VAL_W-1:0] right_value;
  } cell_ctrl_t;

endpackage

[design/spq_cell.sv]
// One cell of the sorted chain: holds one entry and shifts toward either neighbor.
module spq_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  spq_pkg::cell_ctrl_t             ctrl,
  output logic signed [spq_pkg::VAL_W-1:0] value,
  output logic                            valid,
  output logic                            less
);
  import spq_pkg::*;

  logic signed [VAL_W-1:0] value_r, value_nxt;
  logic                    valid_r, valid_nxt;

  assign less  = valid_r && (value_r < ctrl.ins_value);
  assign value = value_r;
  assign valid = valid_r;

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    case (ctrl.op)
      OP_INSERT: begin
        if (!less) begin
          value_nxt = ctrl.left_less ? ctrl.ins_value : ctrl.left_value;
          valid_nxt = ctrl.left_valid;
        end
      end
      OP_REMOVE: begin
        value_nxt = ctrl.right_value;
        valid_nxt = ctrl.right_valid;
      end
      default: begin
        value_nxt = value_r;
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

[design/sorted_insert_priority_queue_top.sv]
// Top level of the sorted-insert minimum priority queue built from a chain of cells.
// The result of an accepted request is in the output register in the next cycle.
// Throughput: one request per cycle while out_ready is high; every cell compares the broadcast value in parallel.
// The input is ready whenever the output register is empty or being taken.
// Reset clears the cell valid bits, the entry count and the output valid flag.
module sorted_insert_priority_queue_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output spq_pkg::out_item_t out_data
);
  import spq_pkg::*;

  logic signed [VAL_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]     cell_valid;
  logic [CAPACITY-1:0]     cell_less;
  cell_ctrl_t              cell_ctrl [CAPACITY];

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;
  logic             in_fire;
  logic             is_full, is_empty;
  cell_op_t         op;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign is_full   = cell_valid[CAPACITY-1];
  assign is_empty  = !cell_valid[0];
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    op = OP_HOLD;
    if (in_fire) begin
      if (in_data.req_type == REQ_INSERT) begin
        op = is_full ? OP_HOLD : OP_INSERT;
      end else begin
        op = is_empty ? OP_HOLD : OP_REMOVE;
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_comb begin
      cell_ctrl[i].op        = op;
      cell_ctrl[i].ins_value = in_data.value;
      if (i == 0) begin
        cell_ctrl[i].left_less  = 1'b1;
        cell_ctrl[i].left_valid = 1'b1;
        cell_ctrl[i].left_value = in_data.value;
      end else begin
        cell_ctrl[i].left_less  = cell_less[(i == 0) ? 0 : i - 1];
        cell_ctrl[i].left_valid = cell_valid[(i == 0) ? 0 : i - 1];
        cell_ctrl[i].left_value = cell_value[(i == 0) ? 0 : i - 1];
      end
      if (i == CAPACITY - 1) begin
        cell_ctrl[i].right_valid = 1'b0;
        cell_ctrl[i].right_value = cell_value[i];
      end else begin
        cell_ctrl[i].right_valid = cell_valid[(i == CAPACITY - 1) ? i : i + 1];
        cell_ctrl[i].right_value = cell_value[(i == CAPACITY - 1) ? i : i + 1];
      end
    end

    spq_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (cell_ctrl[i]),
      .value (cell_value[i]),
      .valid (cell_valid[i]),
      .less  (cell_less[i])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    if (in_fire) begin
      out_valid_nxt  = 1'b1;
      out_nxt.data   = '0;
      out_nxt.status = ST_OK;
      case (op)
        OP_INSERT: count_nxt = count_r + CNT_W'(1);
        OP_REMOVE: begin
          count_nxt    = count_r - CNT_W'(1);
          out_nxt.data = cell_value[0];
        end
        default: begin
          out_nxt.status = (in_data.req_type == REQ_INSERT) ? ST_FULL : ST_EMPTY;
        end
      endcase
      out_nxt.occupancy = OCC_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  a_count_matches_cells : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(count_r))
    else $error("Entry count differs from the number of valid cells.");

  a_valid_contiguous : assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid + CAPACITY'(1)) & cell_valid) == '0)
    else $error("Valid cells are not a contiguous run from the head.");

  a_remove_decrements : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.req_type == REQ_REMOVE && !is_empty)
      |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("A removal transaction did not reduce the entry count.");

  a_full_status : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_FULL) |-> out_r.occupancy == OCC_W'(CAPACITY))
    else $error("A dropped insert reports an occupancy below capacity.");

endmodule
